>>> design/blm_pkg.sv
// Shared types, constants and codes of the battery level monitor.
package blm_pkg;

	localparam int HISTORY_DEPTH_DEF = 15;

	localparam int MV_W = 13;
	localparam int PPTT_W = 14;
	localparam int MARGIN_W = 10;
	localparam int CFG_W = 14;
	localparam int CFG_IDX_W = 3;

	localparam logic [PPTT_W-1:0] LEVEL_UNSET = 14'd10001;
	localparam logic [PPTT_W-1:0] LEVEL_MAX = 14'd16383;

	localparam logic [MV_W-1:0] ABN_LOW_RST = 13'd100;
	localparam logic [MV_W-1:0] ABN_HIGH_RST = 13'd6000;
	localparam logic [MV_W-1:0] PRESENT_RST = 13'd1500;
	localparam logic [MV_W-1:0] SUPPLY_RST = 13'd4300;
	localparam logic [PPTT_W-1:0] LOW_ENTER_RST = 14'd1000;
	localparam logic [PPTT_W-1:0] LOW_EXIT_RST = 14'd1500;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_ABN_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ABN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_ENTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_EXIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd6;

	localparam logic [1:0] PLUG_NONE = 2'd0;
	localparam logic [1:0] PLUG_IN = 2'd1;
	localparam logic [1:0] PLUG_OUT = 2'd2;

	localparam logic [1:0] LED_PULSE = 2'd0;
	localparam logic [1:0] LED_SOLID = 2'd1;
	localparam logic [1:0] LED_LONG = 2'd2;
	localparam logic [1:0] LED_ACTIVE = 2'd3;

	typedef struct packed {
		logic [MV_W-1:0] cell_mv;
		logic [PPTT_W-1:0] charge_pptt;
		logic dock_pin;
		logic charging_pin;
		logic charged_pin;
	} in_item_t;

	typedef struct packed {
		logic available;
		logic vin_present;
		logic external_power;
		logic low_battery;
		logic [PPTT_W-1:0] level_pptt;
		logic shutdown_request;
		logic abnormal;
		logic first_error;
		logic select_dcdc;
		logic [1:0] plug_event;
		logic [1:0] led_pattern;
	} out_item_t;

endpackage

>>> design/blm_ring_mem.sv
// History ring storage: one write port, one read port with registered data.
module blm_ring_mem #(
	parameter int DEPTH = blm_pkg::HISTORY_DEPTH_DEF,
	parameter int AW = 4,
	parameter int DW = blm_pkg::PPTT_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/blm_div.sv
// Divider for small divisors by reciprocal multiplication; the operands and then the quotient are registered.
module blm_div #(
	parameter int ACC_W = 18,
	parameter int DIVR_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic              done,
	output logic [ACC_W-1:0]  quotient
);
	localparam int SHIFT = ACC_W + DIVR_W;
	localparam int RCP_W = SHIFT + 1;
	localparam int PROD_W = ACC_W + SHIFT;
	localparam int TAB_N = 1 << DIVR_W;

	// ceil(2^SHIFT / d): exact floor division for every dividend below 2^ACC_W
	function automatic logic [TAB_N-1:0][RCP_W-1:0] recip_table();
		logic [TAB_N-1:0][RCP_W-1:0] tab;
		tab = '0;
		for (int d = 1; d < TAB_N; d++) begin
			tab[d] = RCP_W'(((64'd1 << SHIFT) + 64'(d) - 64'd1) / 64'(d));
		end
		return tab;
	endfunction

	localparam logic [TAB_N-1:0][RCP_W-1:0] RECIP_TAB = recip_table();

	logic [ACC_W-1:0] dvd_s1;
	logic [RCP_W-1:0] rcp_s1;
	logic valid_s1;
	logic [ACC_W-1:0] quot_s2;
	logic done_s2;
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(dvd_s1) * PROD_W'(rcp_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1 <= dividend;
			rcp_s1 <= RECIP_TAB[divisor];
		end
		if (valid_s1) begin
			quot_s2 <= ACC_W'(prod >> SHIFT);
		end
	end

	assign done = done_s2;
	assign quotient = quot_s2;

endmodule

>>> design/battery_level_monitor.sv
// Battery level monitor top level: thresholds, hysteresis, history average, result register.
//
// channel  direction  handshake            payload
// cfg      in         cfg_we               cfg_index, cfg_data
// in       in         in_valid / in_stall  in_item  (blm_pkg::in_item_t)
// out      out        out_valid / out_stall out_item (blm_pkg::out_item_t)
//
// One item at a time. Each history entry costs one ring read; an empty entry is filled
// by the shared reciprocal divider instead, and the final average uses that divider too.
// Reset clears control state and ring valid bits at once; no clearing pass.
// A result waiting in the output register does not block accepting the next item;
// the walk holds in its last cycle until that result is taken.
module battery_level_monitor #(
	parameter int HISTORY_DEPTH = blm_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  blm_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output blm_pkg::out_item_t             out_item
);
	import blm_pkg::*;

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int ACC_W = PPTT_W + $clog2(HISTORY_DEPTH + 1);
	localparam int DIVR_W = $clog2(HISTORY_DEPTH + 2);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [DIVR_W-1:0] AVG_DIVISOR = DIVR_W'(HISTORY_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_AVG = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [MV_W-1:0] abn_low_q, abn_high_q, present_q, supply_q;
	logic [PPTT_W-1:0] low_enter_q, low_exit_q;
	logic [MARGIN_W-1:0] margin_q;

	logic [2:0] state_q;
	in_item_t item_q;
	logic [ACC_W-1:0] acc_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] slot_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [PPTT_W-1:0] avg_q;
	logic [PPTT_W-1:0] level_q;
	logic low_q, plugged_q, started_q;
	logic out_valid_q;
	out_item_t out_q;

	logic accept, step_done, div_start, div_done, commit, rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [PPTT_W-1:0] rd_data;
	logic [ACC_W-1:0] add_val, acc_sum, div_dividend, div_quot;
	logic [DIVR_W-1:0] div_divisor;

	logic abn, avail, vin, ext, low_d, plugged_d;
	logic [PPTT_W:0] fall_sum;
	logic [PPTT_W-1:0] level_d;
	logic [1:0] plug_d, led_d;

	blm_ring_mem #(
		.DEPTH(HISTORY_DEPTH),
		.AW(IDX_W),
		.DW(PPTT_W)
	) u_ring (
		.clk(clk),
		.wr_en(commit),
		.wr_addr(slot_q),
		.wr_data(item_q.charge_pptt),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	blm_div #(
		.ACC_W(ACC_W),
		.DIVR_W(DIVR_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	assign add_val = (state_q == S_READ) ? ACC_W'(rd_data) : div_quot;
	assign acc_sum = acc_q + add_val;
	assign step_done = ((state_q == S_READ) && valid_q[idx_q]) ||
		((state_q == S_DIV) && div_done);
	assign div_start = ((state_q == S_READ) && !valid_q[idx_q]) ||
		(step_done && (idx_q == LAST_IDX));
	assign div_dividend = step_done ? acc_sum : acc_q;
	assign div_divisor = step_done ? AVG_DIVISOR : (DIVR_W'(idx_q) + DIVR_W'(1));
	assign rd_en = accept || (step_done && (idx_q != LAST_IDX));
	assign rd_addr = accept ? '0 : (idx_q + IDX_W'(1));
	assign commit = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		abn = (item_q.cell_mv < abn_low_q) || (item_q.cell_mv > abn_high_q);
		avail = (item_q.cell_mv > present_q) && !abn;
		vin = (item_q.cell_mv > supply_q) && !abn;
		ext = item_q.charging_pin || item_q.charged_pin || vin;

		if (avail && !low_q && (item_q.charge_pptt < low_enter_q)) begin
			low_d = 1'b1;
		end else if (!avail || (low_q && (item_q.charge_pptt > low_exit_q))) begin
			low_d = 1'b0;
		end else begin
			low_d = low_q;
		end

		fall_sum = {1'b0, avg_q} + (PPTT_W + 1)'(margin_q);
		if (fall_sum < {1'b0, level_q}) begin
			level_d = fall_sum[PPTT_W] ? LEVEL_MAX : fall_sum[PPTT_W-1:0];
		end else if (avg_q > level_q) begin
			level_d = avg_q;
		end else begin
			level_d = level_q;
		end

		plug_d = PLUG_NONE;
		plugged_d = plugged_q;
		if (!plugged_q && ext) begin
			plugged_d = 1'b1;
			plug_d = PLUG_IN;
		end else if (plugged_q && !ext) begin
			plugged_d = 1'b0;
			plug_d = PLUG_OUT;
		end

		if (item_q.charging_pin) begin
			led_d = LED_PULSE;
		end else if (item_q.charged_pin) begin
			led_d = LED_SOLID;
		end else if (vin) begin
			led_d = LED_PULSE;
		end else if (low_d) begin
			led_d = LED_LONG;
		end else begin
			led_d = LED_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abn_low_q <= ABN_LOW_RST;
			abn_high_q <= ABN_HIGH_RST;
			present_q <= PRESENT_RST;
			supply_q <= SUPPLY_RST;
			low_enter_q <= LOW_ENTER_RST;
			low_exit_q <= LOW_EXIT_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ABN_LOW: abn_low_q <= cfg_data[MV_W-1:0];
				CFG_ABN_HIGH: abn_high_q <= cfg_data[MV_W-1:0];
				CFG_PRESENT: present_q <= cfg_data[MV_W-1:0];
				CFG_SUPPLY: supply_q <= cfg_data[MV_W-1:0];
				CFG_LOW_ENTER: low_enter_q <= cfg_data[PPTT_W-1:0];
				CFG_LOW_EXIT: low_exit_q <= cfg_data[PPTT_W-1:0];
				CFG_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			slot_q <= '0;
			valid_q <= '0;
			level_q <= LEVEL_UNSET;
			low_q <= 1'b0;
			plugged_q <= 1'b0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ, S_DIV: begin
					if (step_done) begin
						if (idx_q == LAST_IDX) begin
							state_q <= S_AVG;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							state_q <= S_READ;
						end
					end else if (state_q == S_READ) begin
						state_q <= S_DIV;
					end
				end
				S_AVG: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (commit) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == LAST_IDX) ? '0 : (slot_q + IDX_W'(1));
				level_q <= level_d;
				low_q <= low_d;
				plugged_q <= plugged_d;
				started_q <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			acc_q <= ACC_W'(in_item.charge_pptt);
		end else if (step_done) begin
			acc_q <= acc_sum;
		end
		if ((state_q == S_AVG) && div_done) begin
			avg_q <= div_quot[PPTT_W-1:0];
		end
		if (commit) begin
			out_q.available <= avail;
			out_q.vin_present <= vin;
			out_q.external_power <= ext;
			out_q.low_battery <= low_d;
			out_q.level_pptt <= level_d;
			out_q.shutdown_request <= (avail && (item_q.charge_pptt == '0)) ||
				item_q.dock_pin;
			out_q.abnormal <= abn;
			out_q.first_error <= !started_q && abn;
			out_q.select_dcdc <= !started_q;
			out_q.plug_event <= plug_d;
			out_q.led_pattern <= led_d;
		end
	end

endmodule

>>> tb/battery_level_monitor_tb.sv
`timescale 1ns / 1ps
// Testbench for battery_level_monitor: directed and random samples against a bench predictor.
module battery_level_monitor_tb;
	import blm_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	in_item_t sample_queue[$];
	out_item_t status_queue[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int charge_walk = 5000;

	// predictor copy of the thresholds and of the monitor state
	logic [MV_W-1:0] thr_abn_low, thr_abn_high, thr_present, thr_supply;
	logic [PPTT_W-1:0] thr_low_enter, thr_low_exit;
	logic [MARGIN_W-1:0] thr_margin;
	logic [PPTT_W-1:0] hist_val[DEPTH];
	bit hist_full[DEPTH];
	int hist_slot;
	int unsigned level_now;
	bit low_now, plugged_now, started_now;

	battery_level_monitor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int next_gap();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic out_item_t predict_status(in_item_t s);
		out_item_t r;
		bit abn, avail, vin, ext;
		int unsigned acc;
		int unsigned lowered;
		int i;
		r = '0;
		abn = (s.cell_mv < thr_abn_low) || (s.cell_mv > thr_abn_high);
		avail = (s.cell_mv > thr_present) && !abn;
		vin = (s.cell_mv > thr_supply) && !abn;
		ext = s.charging_pin || s.charged_pin || vin;
		if (!started_now) begin
			r.first_error = abn;
			r.select_dcdc = 1'b1;
			started_now = 1'b1;
		end
		r.shutdown_request = (avail && s.charge_pptt == 0) || s.dock_pin;
		if (avail && !low_now && s.charge_pptt < thr_low_enter)
			low_now = 1'b1;
		else if (!avail || (low_now && s.charge_pptt > thr_low_exit))
			low_now = 1'b0;
		// empty history slots are filled from the running sum
		acc = s.charge_pptt;
		for (i = 0; i < DEPTH; i++) begin
			if (hist_full[i])
				acc += hist_val[i];
			else
				acc += acc / (i + 1);
		end
		acc = acc / (DEPTH + 1);
		hist_val[hist_slot] = s.charge_pptt;
		hist_full[hist_slot] = 1'b1;
		hist_slot = (hist_slot + 1 == DEPTH) ? 0 : hist_slot + 1;
		lowered = acc + thr_margin;
		if (lowered < level_now)
			level_now = (lowered > LEVEL_MAX) ? LEVEL_MAX : lowered;
		else if (acc > level_now)
			level_now = (acc > LEVEL_MAX) ? LEVEL_MAX : acc;
		r.available = avail;
		r.vin_present = vin;
		r.external_power = ext;
		r.low_battery = low_now;
		r.level_pptt = level_now[PPTT_W-1:0];
		r.abnormal = abn;
		r.plug_event = PLUG_NONE;
		if (!plugged_now && ext) begin
			plugged_now = 1'b1;
			r.plug_event = PLUG_IN;
		end else if (plugged_now && !ext) begin
			plugged_now = 1'b0;
			r.plug_event = PLUG_OUT;
		end
		if (s.charging_pin)
			r.led_pattern = LED_PULSE;
		else if (s.charged_pin)
			r.led_pattern = LED_SOLID;
		else if (vin)
			r.led_pattern = LED_PULSE;
		else if (low_now)
			r.led_pattern = LED_LONG;
		else
			r.led_pattern = LED_ACTIVE;
		return r;
	endfunction

	function automatic in_item_t mk_sample(int mv, int pptt, bit dock, bit chg, bit chd);
		in_item_t s;
		s.cell_mv = mv[MV_W-1:0];
		s.charge_pptt = pptt[PPTT_W-1:0];
		s.dock_pin = dock;
		s.charging_pin = chg;
		s.charged_pin = chd;
		return s;
	endfunction

	function automatic in_item_t rand_sample();
		int pick, mv, th, pptt;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			case ($urandom_range(0, 3))
				0: th = thr_abn_low;
				1: th = thr_abn_high;
				2: th = thr_present;
				default: th = thr_supply;
			endcase
			mv = th + int'($urandom_range(0, 4)) - 2;
			if (mv < 0)
				mv = 0;
			else if (mv > 8191)
				mv = 8191;
		end else if (pick < 80) begin
			mv = $urandom_range(0, 8191);
		end else if (pick < 90) begin
			mv = $urandom_range(0, 1) ? 8191 : 0;
		end else begin
			mv = $urandom_range(3000, 4500);
		end
		// charge mostly drifts so the level moves up and down through the margin
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			charge_walk += int'($urandom_range(0, 400)) - 200;
			if (charge_walk < 0)
				charge_walk = 0;
			else if (charge_walk > 10000)
				charge_walk = 10000;
			pptt = charge_walk;
		end else if (pick < 80) begin
			charge_walk = $urandom_range(0, 10000);
			pptt = charge_walk;
		end else if (pick < 90) begin
			th = $urandom_range(0, 1) ? thr_low_enter : thr_low_exit;
			pptt = th + int'($urandom_range(0, 2)) - 1;
		end else if (pick < 95) begin
			pptt = $urandom_range(10001, 16383);
		end else begin
			pptt = 0;
		end
		return mk_sample(mv, pptt, $urandom_range(0, 9) == 0, $urandom_range(0, 2) == 0,
			$urandom_range(0, 2) == 0);
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ABN_LOW: thr_abn_low = data[MV_W-1:0];
			CFG_ABN_HIGH: thr_abn_high = data[MV_W-1:0];
			CFG_PRESENT: thr_present = data[MV_W-1:0];
			CFG_SUPPLY: thr_supply = data[MV_W-1:0];
			CFG_LOW_ENTER: thr_low_enter = data[PPTT_W-1:0];
			CFG_LOW_EXIT: thr_low_exit = data[PPTT_W-1:0];
			CFG_MARGIN: thr_margin = data[MARGIN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_thresholds(int lo, int hi, int pres, int sup, int en, int ex, int mg);
		write_cfg(CFG_ABN_LOW, CFG_W'(lo));
		write_cfg(CFG_ABN_HIGH, CFG_W'(hi));
		write_cfg(CFG_PRESENT, CFG_W'(pres));
		write_cfg(CFG_SUPPLY, CFG_W'(sup));
		write_cfg(CFG_LOW_ENTER, CFG_W'(en));
		write_cfg(CFG_LOW_EXIT, CFG_W'(ex));
		write_cfg(CFG_MARGIN, CFG_W'(mg));
	endtask

	task automatic wait_drained();
		while (sample_queue.size() != 0 || in_valid || status_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				status_queue.push_back(predict_status(in_item));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					in_item <= sample_queue.pop_front();
					in_valid <= 1'b1;
					send_gap = next_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : status_check
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_queue.size() == 0) begin
					$error("status item with no expectation pending");
					errors++;
				end else begin
					want = status_queue.pop_front();
					check_field("available", want.available, out_item.available);
					check_field("vin_present", want.vin_present, out_item.vin_present);
					check_field("external_power", want.external_power,
						out_item.external_power);
					check_field("low_battery", want.low_battery, out_item.low_battery);
					check_field("level_pptt", want.level_pptt, out_item.level_pptt);
					check_field("shutdown_request", want.shutdown_request,
						out_item.shutdown_request);
					check_field("abnormal", want.abnormal, out_item.abnormal);
					check_field("first_error", want.first_error, out_item.first_error);
					check_field("select_dcdc", want.select_dcdc, out_item.select_dcdc);
					check_field("plug_event", want.plug_event, out_item.plug_event);
					check_field("led_pattern", want.led_pattern, out_item.led_pattern);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = next_gap();
			end
		end
	end

	initial begin : stimulus
		int k, ph, lo, hi, pres, sup, en, ex;
		thr_abn_low = ABN_LOW_RST;
		thr_abn_high = ABN_HIGH_RST;
		thr_present = PRESENT_RST;
		thr_supply = SUPPLY_RST;
		thr_low_enter = LOW_ENTER_RST;
		thr_low_exit = LOW_EXIT_RST;
		thr_margin = MARGIN_RST;
		for (k = 0; k < DEPTH; k++) begin
			hist_val[k] = '0;
			hist_full[k] = 1'b0;
		end
		hist_slot = 0;
		level_now = LEVEL_UNSET;
		low_now = 1'b0;
		plugged_now = 1'b0;
		started_now = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset thresholds
		sample_queue.push_back(mk_sample(8191, 5000, 0, 0, 0));
		sample_queue.push_back(mk_sample(0, 0, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 10000, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 0, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 1200, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 1501, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 999, 0, 0, 0));
		sample_queue.push_back(mk_sample(1500, 999, 0, 0, 0));
		sample_queue.push_back(mk_sample(1501, 999, 0, 0, 0));
		sample_queue.push_back(mk_sample(4301, 8000, 0, 0, 0));
		sample_queue.push_back(mk_sample(4300, 8000, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 8000, 0, 1, 0));
		sample_queue.push_back(mk_sample(3700, 8000, 0, 0, 1));
		sample_queue.push_back(mk_sample(3700, 8000, 0, 1, 1));
		sample_queue.push_back(mk_sample(3700, 8000, 1, 0, 0));
		sample_queue.push_back(mk_sample(6000, 8000, 1, 1, 1));
		sample_queue.push_back(mk_sample(6001, 8000, 0, 0, 0));
		sample_queue.push_back(mk_sample(100, 5000, 0, 0, 0));
		sample_queue.push_back(mk_sample(99, 5000, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 16383, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 10001, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 9950, 0, 0, 0));
		sample_queue.push_back(mk_sample(3700, 2000, 0, 0, 0));
		sample_queue.push_back(mk_sample(8191, 16383, 1, 1, 1));
		sample_queue.push_back(mk_sample(0, 0, 0, 0, 0));
		wait_drained();

		for (k = 0; k < 100; k++)
			sample_queue.push_back(rand_sample());
		wait_drained();

		calm = 1'b1;
		write_thresholds(0, 0, 0, 0, 0, 0, 0);
		for (k = 0; k < 60; k++)
			sample_queue.push_back(rand_sample());
		wait_drained();

		calm = 1'b0;
		write_thresholds(8191, 8191, 8191, 8191, 10000, 10000, 1000);
		for (k = 0; k < 60; k++)
			sample_queue.push_back(rand_sample());
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			calm = (ph == 1);
			if (ph % 2 == 0) begin
				lo = $urandom_range(0, 400);
				hi = $urandom_range(5000, 8191);
				pres = $urandom_range(lo, 4000);
				sup = $urandom_range(pres, hi);
				en = $urandom_range(0, 6000);
				ex = $urandom_range(en, 10000);
				write_thresholds(lo, hi, pres, sup, en, ex, $urandom_range(0, 1000));
			end else begin
				write_thresholds($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 16383));
			end
			write_cfg(CFG_SPARE, CFG_W'($urandom_range(0, 16383)));
			for (k = 0; k < 100; k++)
				sample_queue.push_back(rand_sample());
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
